[rtl/core/egc_pkg.sv]
package egc_pkg;

    // Field widths of the sample and result streams.
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned GESTURE_W = 4;
    localparam int unsigned NUM_LANES = 3;

    // Lane order inside the sample and mean arrays.
    localparam int unsigned LANE_FLEX = 0;
    localparam int unsigned LANE_PINCH = 1;
    localparam int unsigned LANE_EXT = 2;

    // Default smoothing window length and batch length.
    localparam int unsigned AVG_TAPS_DEF  = 20;
    localparam int unsigned BATCH_LEN_DEF = 10;

    // Stream widths, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 40;

    // Decision tree thresholds on the batch means.
    localparam logic [SAMPLE_W-1:0] TH_EXT_LOW    = SAMPLE_W'(220);
    localparam logic [SAMPLE_W-1:0] TH_EXT_MID    = SAMPLE_W'(290);
    localparam logic [SAMPLE_W-1:0] TH_EXT_HIGH   = SAMPLE_W'(335);
    localparam logic [SAMPLE_W-1:0] TH_PINCH_FIST = SAMPLE_W'(310);
    localparam logic [SAMPLE_W-1:0] TH_PINCH_PIN  = SAMPLE_W'(360);
    localparam logic [SAMPLE_W-1:0] TH_PINCH_MIDT = SAMPLE_W'(325);
    localparam logic [SAMPLE_W-1:0] TH_PINCH_PEAC = SAMPLE_W'(290);
    localparam logic [SAMPLE_W-1:0] TH_PINCH_IDX  = SAMPLE_W'(305);
    localparam logic [SAMPLE_W-1:0] TH_PINCH_PNKY = SAMPLE_W'(385);
    localparam logic [SAMPLE_W-1:0] TH_FLEX_MID   = SAMPLE_W'(93);
    localparam logic [SAMPLE_W-1:0] TH_FLEX_POINT = SAMPLE_W'(130);

    // Gesture codes.
    typedef enum logic [GESTURE_W-1:0] {
        G_REST   = 4'd0,
        G_FIST   = 4'd1,
        G_PINCH  = 4'd2,
        G_PEACE  = 4'd3,
        G_POINT  = 4'd4,
        G_THUMB  = 4'd5,
        G_INDEX  = 4'd6,
        G_MIDDLE = 4'd7,
        G_RING   = 4'd8,
        G_PINKY  = 4'd9,
        G_OKTH   = 4'd10,
        G_MIDTH  = 4'd11
    } t_gesture;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Pipeline controls shared by all lanes.
    typedef struct packed {
        logic accept;      // a new sample request is taken this cycle
        logic old_valid;   // the ring slot being replaced holds a written sample
        logic avg_load;    // the average stage advances
        logic batch_fire;  // a valid average enters the batch accumulator
        logic batch_last;  // that average completes the batch
        logic mean_load;   // the completed batch sum moves to the mean stage
    } t_lane_ctrl;

endpackage

[rtl/core/egc_lane.sv]
module egc_lane #(
    parameter int unsigned AVG_TAPS  = egc_pkg::AVG_TAPS_DEF,
    parameter int unsigned BATCH_LEN = egc_pkg::BATCH_LEN_DEF,
    localparam int unsigned PW = $clog2(AVG_TAPS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  egc_pkg::t_lane_ctrl  i_ctrl,
    input  logic [PW-1:0]        i_pos,
    input  egc_pkg::t_sample     i_sample,
    output egc_pkg::t_sample     o_mean
);

    localparam int unsigned SW  = egc_pkg::SAMPLE_W;
    localparam int unsigned WSW = $clog2(AVG_TAPS * ((1 << SW) - 1) + 1);
    localparam int unsigned BSW = $clog2(BATCH_LEN * ((1 << SW) - 1) + 1);

    // Reciprocal constants: x / D == (x * ceil(2^S / D)) >> S for all x below 2^N
    // when S = N + ceil(log2(D)).
    localparam int unsigned AVG_SH = WSW + $clog2(AVG_TAPS);
    localparam int unsigned AVG_MW = WSW + 2;
    localparam logic [AVG_MW-1:0] AVG_RECIP =
        AVG_MW'(((64'd1 << AVG_SH) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));
    localparam int unsigned BAT_SH = BSW + $clog2(BATCH_LEN);
    localparam int unsigned BAT_MW = BSW + 2;
    localparam logic [BAT_MW-1:0] BAT_RECIP =
        BAT_MW'(((64'd1 << BAT_SH) + 64'(BATCH_LEN) - 64'd1) / 64'(BATCH_LEN));

    logic [SW-1:0]  r_ring [AVG_TAPS];
    logic [WSW-1:0] r_wsum;
    logic [WSW-1:0] n_wsum;
    logic [SW-1:0]  r_avg;
    logic [BSW-1:0] r_bsum;
    logic [BSW-1:0] n_bsum;
    logic [BSW-1:0] r_csum;
    logic [SW-1:0]  r_mean;
    logic [SW-1:0]  old_sample;
    logic [WSW+AVG_MW-1:0] avg_prod;
    logic [BSW+BAT_MW-1:0] mean_prod;

    // Running window sum: drop the sample being overwritten, add the new one.
    assign old_sample = i_ctrl.old_valid ? r_ring[i_pos] : '0;
    assign n_wsum     = r_wsum - WSW'(old_sample) + WSW'(i_sample);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_ring[i_pos] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
        end else if (i_ctrl.accept) begin
            r_wsum <= n_wsum;
        end
    end

    // Moving average by reciprocal multiplication.
    assign avg_prod = (WSW+AVG_MW)'(r_wsum) * (WSW+AVG_MW)'(AVG_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.avg_load) begin
            r_avg <= SW'(avg_prod >> AVG_SH);
        end
    end

    // Batch accumulator; the completed sum is handed on and the accumulator cleared.
    assign n_bsum = r_bsum + BSW'(r_avg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsum <= '0;
        end else if (i_ctrl.batch_fire) begin
            r_bsum <= i_ctrl.batch_last ? '0 : n_bsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.batch_fire && i_ctrl.batch_last) begin
            r_csum <= n_bsum;
        end
    end

    // Batch mean by reciprocal multiplication.
    assign mean_prod = (BSW+BAT_MW)'(r_csum) * (BSW+BAT_MW)'(BAT_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mean_load) begin
            r_mean <= SW'(mean_prod >> BAT_SH);
        end
    end

    assign o_mean = r_mean;

endmodule

[rtl/core/egc_merge.sv]
module egc_merge (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  egc_pkg::t_sample                  i_mean_flex,
    input  egc_pkg::t_sample                  i_mean_pinch,
    input  egc_pkg::t_sample                  i_mean_ext,
    output logic [egc_pkg::GESTURE_W-1:0]     o_gesture,
    output egc_pkg::t_sample                  o_mean_flex,
    output egc_pkg::t_sample                  o_mean_pinch,
    output egc_pkg::t_sample                  o_mean_ext
);

    egc_pkg::t_gesture gesture;
    egc_pkg::t_gesture r_gesture;
    egc_pkg::t_sample  r_mean_flex;
    egc_pkg::t_sample  r_mean_pinch;
    egc_pkg::t_sample  r_mean_ext;

    // Threshold tree: extension picks the group, pinch and flexor pick within it.
    always_comb begin
        if (i_mean_ext < egc_pkg::TH_EXT_LOW) begin
            if (i_mean_pinch > egc_pkg::TH_PINCH_PIN) begin
                gesture = egc_pkg::G_PINCH;
            end else if (i_mean_pinch > egc_pkg::TH_PINCH_FIST) begin
                gesture = egc_pkg::G_FIST;
            end else begin
                gesture = egc_pkg::G_REST;
            end
        end else if (i_mean_ext < egc_pkg::TH_EXT_MID) begin
            if (i_mean_pinch > egc_pkg::TH_PINCH_MIDT) begin
                gesture = egc_pkg::G_MIDTH;
            end else if (i_mean_pinch > egc_pkg::TH_PINCH_PEAC) begin
                gesture = egc_pkg::G_PEACE;
            end else begin
                gesture = egc_pkg::G_OKTH;
            end
        end else if (i_mean_ext < egc_pkg::TH_EXT_HIGH) begin
            if (i_mean_pinch > egc_pkg::TH_PINCH_IDX) begin
                gesture = egc_pkg::G_INDEX;
            end else if (i_mean_flex < egc_pkg::TH_FLEX_MID) begin
                gesture = egc_pkg::G_MIDDLE;
            end else begin
                gesture = egc_pkg::G_THUMB;
            end
        end else begin
            if (i_mean_pinch > egc_pkg::TH_PINCH_PNKY) begin
                gesture = egc_pkg::G_PINKY;
            end else if (i_mean_flex > egc_pkg::TH_FLEX_POINT) begin
                gesture = egc_pkg::G_POINT;
            end else begin
                gesture = egc_pkg::G_RING;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gesture    <= gesture;
            r_mean_flex  <= i_mean_flex;
            r_mean_pinch <= i_mean_pinch;
            r_mean_ext   <= i_mean_ext;
        end
    end

    assign o_gesture    = r_gesture;
    assign o_mean_flex  = r_mean_flex;
    assign o_mean_pinch = r_mean_pinch;
    assign o_mean_ext   = r_mean_ext;

endmodule

[rtl/core/emg_gesture_classifier.sv]
// A result appears on the master side once the request that completes its batch has passed
// the window sum, average, batch sum, mean and output registers; other requests give none.
// Throughput: one sample request per cycle; up to three finished results are buffered
// (batch, mean and output registers) before back-pressure reaches the slave side.
// Reset (synchronous, active low) empties the windows, sums, batch count and pipeline.
module emg_gesture_classifier #(
    parameter int unsigned AVG_TAPS  = egc_pkg::AVG_TAPS_DEF,
    parameter int unsigned BATCH_LEN = egc_pkg::BATCH_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // raw_flex [11:0], raw_pinch [23:12], raw_extension [35:24], zero [39:36]
    input  logic [egc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // gesture [3:0], mean_flex [15:4], mean_pinch [27:16], mean_extension [39:28]
    output logic [egc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int unsigned SW = egc_pkg::SAMPLE_W;
    localparam int unsigned PW = $clog2(AVG_TAPS);
    localparam int unsigned CW = (BATCH_LEN > 1) ? $clog2(BATCH_LEN) : 1;

    logic [PW-1:0] r_pos;
    logic          r_wrapped;
    logic [CW-1:0] r_bcnt;
    logic          r_a_valid;
    logic          r_b_valid;
    logic          r_c_valid;
    logic          r_m_valid;
    logic          r_o_valid;

    logic out_free;
    logic mean_adv;
    logic csum_adv;
    logic front_adv;
    logic accept;
    logic batch_last;
    logic batch_fire;
    logic mean_load;
    logic out_load;

    egc_pkg::t_lane_ctrl lane_ctrl;
    egc_pkg::t_sample    samples [egc_pkg::NUM_LANES];
    egc_pkg::t_sample    means   [egc_pkg::NUM_LANES];

    logic [egc_pkg::GESTURE_W-1:0] res_gesture;
    egc_pkg::t_sample              res_flex;
    egc_pkg::t_sample              res_pinch;
    egc_pkg::t_sample              res_ext;

    // Stage handshakes from the output back to the input.
    assign out_free   = !r_o_valid || m_axis_tready;
    assign mean_adv   = !r_m_valid || out_free;
    assign csum_adv   = !r_c_valid || mean_adv;
    assign batch_last = (r_bcnt == CW'(BATCH_LEN - 1));
    assign front_adv  = !(r_b_valid && batch_last && !csum_adv);
    assign accept     = s_axis_tvalid && front_adv;
    assign batch_fire = front_adv && r_b_valid;
    assign mean_load  = r_c_valid && mean_adv;
    assign out_load   = r_m_valid && out_free;

    assign s_axis_tready = front_adv;

    assign lane_ctrl = '{
        accept:     accept,
        old_valid:  r_wrapped,
        avg_load:   front_adv,
        batch_fire: batch_fire,
        batch_last: batch_last,
        mean_load:  mean_load
    };

    // Ring position, first-lap flag, batch count and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_bcnt    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (r_pos == PW'(AVG_TAPS - 1)) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (front_adv) begin
                r_a_valid <= accept;
                r_b_valid <= r_a_valid;
            end
            if (batch_fire) begin
                r_bcnt <= batch_last ? '0 : r_bcnt + 1'b1;
            end
            if (batch_fire && batch_last) begin
                r_c_valid <= 1'b1;
            end else if (mean_adv) begin
                r_c_valid <= 1'b0;
            end
            if (mean_load) begin
                r_m_valid <= 1'b1;
            end else if (out_free) begin
                r_m_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // One smoothing and batching lane per sensor channel.
    assign samples[egc_pkg::LANE_FLEX]  = s_axis_tdata[SW-1:0];
    assign samples[egc_pkg::LANE_PINCH] = s_axis_tdata[2*SW-1:SW];
    assign samples[egc_pkg::LANE_EXT]   = s_axis_tdata[3*SW-1:2*SW];

    for (genvar g = 0; g < egc_pkg::NUM_LANES; g++) begin : g_lane
        egc_lane #(
            .AVG_TAPS  (AVG_TAPS),
            .BATCH_LEN (BATCH_LEN)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lane_ctrl),
            .i_pos    (r_pos),
            .i_sample (samples[g]),
            .o_mean   (means[g])
        );
    end

    // Gesture decision on the three batch means.
    egc_merge u_merge (
        .i_clk        (i_clk),
        .i_load       (out_load),
        .i_mean_flex  (means[egc_pkg::LANE_FLEX]),
        .i_mean_pinch (means[egc_pkg::LANE_PINCH]),
        .i_mean_ext   (means[egc_pkg::LANE_EXT]),
        .o_gesture    (res_gesture),
        .o_mean_flex  (res_flex),
        .o_mean_pinch (res_pinch),
        .o_mean_ext   (res_ext)
    );

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {res_ext, res_pinch, res_flex, res_gesture};

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int CLK_HALF   = 5;
    localparam int RST_CYCLES = 12;
    localparam int CYCLE_CAP  = 300000;
    localparam int HOLD_LEN   = 400;
    localparam int CALM_TAIL  = 60;

    // One request on the slave side: a sample from each sensor lane.
    typedef struct packed {
        egc_pkg::t_sample ext;
        egc_pkg::t_sample pinch;
        egc_pkg::t_sample flex;
    } t_emg_triple;

    // One finished batch as the master side should report it.
    typedef struct {
        egc_pkg::t_gesture gesture;
        egc_pkg::t_sample  mean_flex;
        egc_pkg::t_sample  mean_pinch;
        egc_pkg::t_sample  mean_ext;
    } t_gesture_report;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // raw_flex, raw_pinch, raw_extension, zero pad
    logic [egc_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // gesture, mean_flex, mean_pinch, mean_extension
    logic [egc_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // Requests still to be offered, and batch reports still to arrive.
    t_emg_triple     sample_q[$];
    t_gesture_report pending_gestures[$];

    // Predictor state: smoothing rings, running sums and the open batch.
    egc_pkg::t_sample ring[egc_pkg::NUM_LANES][egc_pkg::AVG_TAPS_DEF] = '{default: '0};
    logic [16:0]      win_sum[egc_pkg::NUM_LANES] = '{default: '0};
    logic [15:0]      batch_sum[egc_pkg::NUM_LANES] = '{default: '0};
    int               ring_pos = 0;
    int               batch_cnt = 0;

    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          taken_cnt = 0;
    int          report_cnt = 0;
    int          stall_cycles = 0;
    logic [11:0] gestures_seen = '0;
    logic        in_acc;
    int          send_gap = 0;
    int          rcv_gap = 0;
    int          hold_left = 0;
    bit          pressure_done = 1'b0;

    emg_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Threshold tree on the three batch means.
    function automatic egc_pkg::t_gesture classify_gesture(input egc_pkg::t_sample f,
                                                           input egc_pkg::t_sample p,
                                                           input egc_pkg::t_sample e);
        if (e < egc_pkg::TH_EXT_LOW) begin
            if (p > egc_pkg::TH_PINCH_PIN) return egc_pkg::G_PINCH;
            if (p > egc_pkg::TH_PINCH_FIST) return egc_pkg::G_FIST;
            return egc_pkg::G_REST;
        end
        if (e < egc_pkg::TH_EXT_MID) begin
            if (p > egc_pkg::TH_PINCH_MIDT) return egc_pkg::G_MIDTH;
            if (p > egc_pkg::TH_PINCH_PEAC) return egc_pkg::G_PEACE;
            return egc_pkg::G_OKTH;
        end
        if (e < egc_pkg::TH_EXT_HIGH) begin
            if (p > egc_pkg::TH_PINCH_IDX) return egc_pkg::G_INDEX;
            if (f < egc_pkg::TH_FLEX_MID) return egc_pkg::G_MIDDLE;
            return egc_pkg::G_THUMB;
        end
        if (p > egc_pkg::TH_PINCH_PNKY) return egc_pkg::G_PINKY;
        if (f > egc_pkg::TH_FLEX_POINT) return egc_pkg::G_POINT;
        return egc_pkg::G_RING;
    endfunction

    // Smooth one accepted request, add it to the batch and queue a report when it closes.
    task automatic smooth_and_batch(input logic [egc_pkg::S_TDATA_W-1:0] word);
        egc_pkg::t_sample smp[egc_pkg::NUM_LANES];
        logic [16:0]      avg;
        egc_pkg::t_sample mean[egc_pkg::NUM_LANES];
        t_gesture_report  rep;
        smp[egc_pkg::LANE_FLEX]  = word[11:0];
        smp[egc_pkg::LANE_PINCH] = word[23:12];
        smp[egc_pkg::LANE_EXT]   = word[35:24];
        for (int ln = 0; ln < egc_pkg::NUM_LANES; ln++) begin
            win_sum[ln] = win_sum[ln] - 17'(ring[ln][ring_pos]) + 17'(smp[ln]);
            ring[ln][ring_pos] = smp[ln];
            avg = win_sum[ln] / egc_pkg::AVG_TAPS_DEF;
            batch_sum[ln] = batch_sum[ln] + avg[15:0];
        end
        ring_pos = (ring_pos == egc_pkg::AVG_TAPS_DEF - 1) ? 0 : ring_pos + 1;
        batch_cnt++;
        if (batch_cnt == egc_pkg::BATCH_LEN_DEF) begin
            for (int ln = 0; ln < egc_pkg::NUM_LANES; ln++) begin
                mean[ln] = egc_pkg::t_sample'(batch_sum[ln] / egc_pkg::BATCH_LEN_DEF);
                batch_sum[ln] = '0;
            end
            rep.mean_flex  = mean[egc_pkg::LANE_FLEX];
            rep.mean_pinch = mean[egc_pkg::LANE_PINCH];
            rep.mean_ext   = mean[egc_pkg::LANE_EXT];
            rep.gesture    = classify_gesture(mean[egc_pkg::LANE_FLEX],
                                              mean[egc_pkg::LANE_PINCH],
                                              mean[egc_pkg::LANE_EXT]);
            pending_gestures.push_back(rep);
            batch_cnt = 0;
        end
    endtask

    task automatic add_sample(input int f, input int p, input int e);
        t_emg_triple t;
        t.flex  = egc_pkg::t_sample'(f);
        t.pinch = egc_pkg::t_sample'(p);
        t.ext   = egc_pkg::t_sample'(e);
        sample_q.push_back(t);
    endtask

    // A value on, just beside, or away from a threshold of the tree.
    function automatic int near_threshold(input int th);
        case ($urandom_range(0, 5))
            0: return th - 1;
            1: return th;
            2: return th + 1;
            3: return $urandom_range(0, 600);
            4: return $urandom_range(0, 4095);
            default: return th + $urandom_range(0, 20) - 10;
        endcase
    endfunction

    // A run of requests aimed at one branch of the tree, held long enough to fill the
    // window so that the batch means land on the chosen values.
    task automatic add_gesture_run();
        int ext_th[3]   = '{220, 290, 335};
        int pinch_th[6] = '{360, 310, 325, 290, 305, 385};
        int flex_th[2]  = '{93, 130};
        int f;
        int p;
        int e;
        int len;
        bit jitter;
        e = near_threshold(ext_th[$urandom_range(0, 2)]);
        p = near_threshold(pinch_th[$urandom_range(0, 5)]);
        f = near_threshold(flex_th[$urandom_range(0, 1)]);
        // Some runs are cut short so that a batch straddles two targets.
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 15) : $urandom_range(20, 35);
        jitter = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            if (jitter) begin
                add_sample(f + $urandom_range(0, 4) - 2, p + $urandom_range(0, 4) - 2,
                           e + $urandom_range(0, 4) - 2);
            end else begin
                add_sample(f, p, e);
            end
        end
    endtask

    // Slave-side driver: offers the next request or idles for a burst.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || in_acc) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (sample_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (sample_q.size() > CALM_TAIL && (taken_cnt / 64) % 2 == 0
                         && $urandom_range(0, 6) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= {4'b0, sample_q.pop_front()};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Master-side ready: random stalls, one long hold-off, none near the end.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!pressure_done && taken_cnt >= 150) begin
            pressure_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            m_axis_tready <= 1'b0;
        end else if (sample_q.size() > CALM_TAIL && (taken_cnt / 80) % 2 == 0
                     && $urandom_range(0, 5) == 0) begin
            rcv_gap = $urandom_range(1, 12) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted report.
    always @(posedge i_clk) begin
        t_gesture_report exp_rep;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("emg_gesture_classifier regression: fail");
            $finish;
        end else if (!i_rst_n) begin
            in_acc <= 1'b0;
        end else begin
            in_acc <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                taken_cnt++;
                smooth_and_batch(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_gestures.size() == 0) begin
                    $error("unexpected result: tdata %h", m_axis_tdata);
                    err_cnt++;
                end else begin
                    exp_rep = pending_gestures.pop_front();
                    report_cnt++;
                    gestures_seen[exp_rep.gesture] = 1'b1;
                    if (m_axis_tdata[3:0] !== exp_rep.gesture) begin
                        $error("gesture: expected %0d, got %0d", exp_rep.gesture,
                               m_axis_tdata[3:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[15:4] !== exp_rep.mean_flex) begin
                        $error("mean_flex: expected %0d, got %0d", exp_rep.mean_flex,
                               m_axis_tdata[15:4]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[27:16] !== exp_rep.mean_pinch) begin
                        $error("mean_pinch: expected %0d, got %0d", exp_rep.mean_pinch,
                               m_axis_tdata[27:16]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[39:28] !== exp_rep.mean_ext) begin
                        $error("mean_extension: expected %0d, got %0d", exp_rep.mean_ext,
                               m_axis_tdata[39:28]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Reset, stimulus and end of run.
    initial begin
        int n_on;
        i_rst_n = 1'b0;

        // Full-scale samples while the window still holds its initial zeros.
        for (int k = 0; k < 10; k++) add_sample(4095, 4095, 4095);
        // Alternating bit patterns, so every input bit takes both values.
        for (int k = 0; k < 5; k++) begin
            add_sample(12'hAAA, 12'h555, 12'hAAA);
            add_sample(12'h555, 12'hAAA, 12'h555);
        end
        // All zeros, then mixed extremes across the lanes.
        for (int k = 0; k < 3; k++) add_sample(0, 0, 0);
        add_sample(4095, 0, 4095);
        add_sample(0, 4095, 0);

        // Mostly runs aimed at the tree, with some unshaped noise between them.
        while (sample_q.size() < 450) begin
            if ($urandom_range(0, 4) == 0) begin
                n_on = $urandom_range(3, 15);
                for (int k = 0; k < n_on; k++) begin
                    add_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095));
                end
            end else begin
                add_gesture_run();
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_gestures.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Run covered %0d sample requests and %0d batch reports, %0d of 12 gestures.",
                 taken_cnt, report_cnt, $countones(gestures_seen));
        $display("Slave side was held off for %0d cycles in total.", stall_cycles);
        if (err_cnt == 0) begin
            $display("emg_gesture_classifier regression: pass");
        end else begin
            $display("emg_gesture_classifier regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/egc_pkg.sv
rtl/core/egc_lane.sv
rtl/core/egc_merge.sv
rtl/core/emg_gesture_classifier.sv
sim/tb.sv
